// File: design/multi_led_blink_controller_defines.svh
// Assertion macros used by the LED blink controller's control module.
`ifndef MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define LBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define LBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/lbc_pkg.sv
package lbc_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PIN_W        = 8;

   // Item kinds.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_BLINK = 2'd2;
   localparam logic [1:0] KIND_STOP  = 2'd3;

   // Channel colour states.
   localparam logic [1:0] COLOUR_OFF = 2'd0;
   localparam logic [1:0] COLOUR_ONE = 2'd1;
   localparam logic [1:0] COLOUR_TWO = 2'd2;

   // Blink toggle modes.
   localparam logic [1:0] MODE_HOLD    = 2'd0;
   localparam logic [1:0] MODE_OFF_ONE = 2'd1;
   localparam logic [1:0] MODE_OFF_TWO = 2'd2;
   localparam logic [1:0] MODE_TWO_ONE = 2'd3;

   typedef struct packed {
      logic accept;
      logic exec;
      logic walk_step;
      logic load_result;
   } lbc_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic walk_last;
      logic out_free;
   } lbc_sts_type;

endpackage

// File: design/multi_led_blink_controller.sv
// Bank of LED channels with per-channel blinking.
//
// Input channel (req_): one item per handshake; req_tuser carries the kind
// (tick, set, blink, stop) and req_tdata the channel, time and blink fields.
// Result channel (rsp_): one item per input item, in order, giving both pin
// vectors in rsp_tdata and the bad-request flag in rsp_tuser.
// The csr_ port writes the two-colour mask; write it only while
// no item is in flight.
//
// An item is handled one at a time. A set, blink or stop item passes through
// the exec and finish states; a tick walks the channels between them, because
// a single compare unit visits one channel per cycle. Ready rises at the same
// clock edge that loads the result register.
// The result register lets the next item be accepted while the previous
// result waits; if the receiver stalls longer, the block holds its finished
// result and drops ready until the register frees up.
// Synchronous reset clears the mask and all channel state to off, not
// blinking, with zero times; ready rises in the cycle after reset is released.
module multi_led_blink_controller
   import lbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [PIN_W-1:0]  csr_wdata,      // bicolor_mask
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [55:0]       req_tdata,      // channel, now_ms, set_value, half_period_ms,
                                             // blink_mode, zero pad
   input  logic [1:0]        req_tuser,      // kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,      // primary_pins, secondary_pins
   output logic              rsp_tuser       // bad_request
);

   lbc_cmd_type cmd;
   lbc_sts_type sts;

   lbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lbc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// File: design/lbc_ctrl.sv
`include "multi_led_blink_controller_defines.svh"

module lbc_ctrl
   import lbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  lbc_sts_type sts,
   output lbc_cmd_type cmd
);

   typedef enum logic [1:0] {
      IDLE,
      EXEC,
      WALK,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_tvalid && ready_ff) state_in = EXEC;
         end
         EXEC: begin
            state_in = sts.is_tick ? WALK : FINISH;
         end
         WALK: begin
            if (sts.walk_last) state_in = FINISH;
         end
         FINISH: begin
            if (sts.out_free) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == IDLE);
      end
   end

   assign req_tready      = ready_ff;
   assign cmd.accept      = req_tvalid && ready_ff;
   assign cmd.exec        = (state_ff == EXEC);
   assign cmd.walk_step   = (state_ff == WALK);
   assign cmd.load_result = (state_ff == FINISH) && sts.out_free;

   `LBC_ASSERT_NEXT(a_accept_drops_ready, req_tvalid && ready_ff, !ready_ff,
      "ready stayed high after an item was accepted")
   `LBC_ASSERT_NOW(a_ready_only_idle, ready_ff, state_ff == IDLE,
      "ready is high outside the idle state")
   `LBC_ASSERT_NEXT(a_walk_ends_in_finish, state_ff == WALK && sts.walk_last,
      state_ff == FINISH, "channel walk did not end in the finish state")
   `LBC_ASSERT_NEXT(a_finish_hands_off, state_ff == FINISH && sts.out_free,
      state_ff == IDLE && ready_ff, "result handoff did not return to idle")

endmodule

// File: design/lbc_datapath.sv
module lbc_datapath
   import lbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [PIN_W-1:0]  csr_wdata,
   input  logic [1:0]        req_tuser,
   input  logic [55:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic              rsp_tuser,
   input  lbc_cmd_type       cmd,
   output lbc_sts_type       sts
);

   function automatic logic is_bicolor(input logic [CH_IDX_W-1:0] idx,
                                       input logic [PIN_W-1:0] mask);
      return (32'(idx) < 32'd8) && mask[3'(idx)];
   endfunction

   function automatic logic [1:0] step_colour(input logic [1:0] s, input logic [1:0] m,
                                              input logic bi);
      logic [1:0] r;
      r = s;
      if (!bi || m == MODE_OFF_ONE) begin
         r = (s == COLOUR_OFF) ? COLOUR_ONE : COLOUR_OFF;
      end else if (m == MODE_OFF_TWO) begin
         r = (s == COLOUR_OFF) ? COLOUR_TWO : COLOUR_OFF;
      end else if (m == MODE_TWO_ONE) begin
         r = (s == COLOUR_TWO) ? COLOUR_ONE : COLOUR_TWO;
      end
      return r;
   endfunction

   logic [PIN_W-1:0]    mask_ff;
   logic                blinking_ff [NUM_CHANNELS];
   logic [15:0]         half_period_ff [NUM_CHANNELS];
   logic [1:0]          mode_ff [NUM_CHANNELS];
   logic [31:0]         last_ms_ff [NUM_CHANNELS];
   logic [1:0]          colour_ff [NUM_CHANNELS];

   // Latched item.
   logic [1:0]          kind_ff;
   logic [2:0]          ch_ff;
   logic [31:0]         now_ff;
   logic [1:0]          setv_ff;
   logic [15:0]         hp_ff;
   logic [1:0]          bmode_ff;
   logic                bad_ff;

   logic [CH_IDX_W-1:0] walk_idx_ff;
   logic [CH_IDX_W-1:0] ch_idx;
   logic                ch_in_range;
   logic [31:0]         elapsed;
   logic                walk_hit;
   logic [1:0]          walk_colour;

   logic                out_valid_ff;
   logic [PIN_W-1:0]    prim_ff, sec_ff;
   logic                out_bad_ff;
   logic [PIN_W-1:0]    prim, sec;

   assign ch_idx      = CH_IDX_W'(ch_ff);
   assign ch_in_range = 32'(ch_ff) < 32'(NUM_CHANNELS);

   // Elapsed time wraps modulo 2^32.
   assign elapsed     = now_ff - last_ms_ff[walk_idx_ff];
   assign walk_hit    = blinking_ff[walk_idx_ff] && (elapsed >= {16'd0, half_period_ff[walk_idx_ff]});
   assign walk_colour = step_colour(colour_ff[walk_idx_ff], mode_ff[walk_idx_ff],
                                    is_bicolor(walk_idx_ff, mask_ff));

   for (genvar g = 0; g < PIN_W; g++) begin : g_pin
      if (g < NUM_CHANNELS) begin : g_live
         assign prim[g] = (colour_ff[g] == COLOUR_ONE);
         assign sec[g]  = (colour_ff[g] == COLOUR_TWO) && mask_ff[g];
      end else begin : g_none
         assign prim[g] = 1'b0;
         assign sec[g]  = 1'b0;
      end
   end

   assign sts.is_tick   = (kind_ff == KIND_TICK);
   assign sts.walk_last = (walk_idx_ff == CH_IDX_W'(NUM_CHANNELS - 1));
   assign sts.out_free  = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= req_tuser;
         ch_ff    <= req_tdata[2:0];
         now_ff   <= req_tdata[34:3];
         setv_ff  <= req_tdata[36:35];
         hp_ff    <= req_tdata[52:37];
         bmode_ff <= req_tdata[54:53];
      end
      if (cmd.load_result) begin
         prim_ff    <= prim;
         sec_ff     <= sec;
         out_bad_ff <= bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
         bad_ff       <= 1'b0;
         walk_idx_ff  <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            blinking_ff[i]    <= 1'b0;
            half_period_ff[i] <= '0;
            mode_ff[i]        <= MODE_HOLD;
            last_ms_ff[i]     <= '0;
            colour_ff[i]      <= COLOUR_OFF;
         end
      end else begin
         if (csr_we) mask_ff <= csr_wdata;

         if (cmd.load_result) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end

         if (cmd.accept) begin
            bad_ff      <= 1'b0;
            walk_idx_ff <= '0;
         end

         if (cmd.exec && kind_ff != KIND_TICK && ch_in_range) begin
            case (kind_ff)
               KIND_SET: begin
                  blinking_ff[ch_idx] <= 1'b0;
                  if (setv_ff == COLOUR_OFF || setv_ff == COLOUR_ONE) begin
                     colour_ff[ch_idx] <= setv_ff;
                  end else if (setv_ff == COLOUR_TWO && is_bicolor(ch_idx, mask_ff)) begin
                     colour_ff[ch_idx] <= COLOUR_TWO;
                  end else begin
                     bad_ff <= 1'b1;
                  end
               end
               KIND_BLINK: begin
                  blinking_ff[ch_idx]    <= 1'b1;
                  half_period_ff[ch_idx] <= hp_ff;
                  mode_ff[ch_idx]        <= bmode_ff;
               end
               KIND_STOP: begin
                  blinking_ff[ch_idx] <= 1'b0;
                  colour_ff[ch_idx]   <= COLOUR_OFF;
               end
               default: ;
            endcase
         end

         if (cmd.walk_step) begin
            if (walk_hit) begin
               last_ms_ff[walk_idx_ff] <= now_ff;
               colour_ff[walk_idx_ff]  <= walk_colour;
            end
            if (!sts.walk_last) walk_idx_ff <= walk_idx_ff + 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {sec_ff, prim_ff};
   assign rsp_tuser  = out_bad_ff;

endmodule

// File: tb/sv/multi_led_blink_controller_tb.sv
`timescale 1ns / 1ps

module multi_led_blink_controller_tb;
   import lbc_pkg::*;

   localparam int          SETTLE_CYCLES = NUM_CHANNELS + 8;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam logic [1:0]  SET_INVALID   = 2'd3;

   typedef struct packed {
      logic [7:0] primary;
      logic [7:0] secondary;
      logic       bad;
   } pin_view_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [PIN_W-1:0]  csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [55:0]       req_tdata = '0;   // channel, now_ms, set_value, half_period_ms,
                                        // blink_mode, zero pad
   logic [1:0]        req_tuser = '0;   // kind
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;        // primary_pins, secondary_pins
   logic              rsp_tuser;        // bad_request

   // Predicted channel state.
   logic [7:0]        led_mask;
   logic              led_blinking [NUM_CHANNELS];
   logic [15:0]       led_half     [NUM_CHANNELS];
   logic [1:0]        led_mode     [NUM_CHANNELS];
   logic [31:0]       led_last     [NUM_CHANNELS];
   logic [1:0]        led_colour   [NUM_CHANNELS];

   pin_view_type      pin_forecast [$];
   pin_view_type      seen_view;
   pin_view_type      want_view;

   int unsigned       fail_count = 0;
   int unsigned       n_items = 0;
   int unsigned       n_results = 0;
   int unsigned       n_ticks = 0;
   int unsigned       n_toggles = 0;
   int unsigned       n_refused = 0;
   int unsigned       cycle_count = 0;
   int unsigned       rsp_hold_cycles = 0;
   bit                no_idle = 1'b0;
   logic [31:0]       clock_ms = '0;

   multi_led_blink_controller dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void step_colour(input int c);
      logic [1:0] s;
      s = led_colour[c];
      if (!led_mask[c] || led_mode[c] == MODE_OFF_ONE) begin
         led_colour[c] = (s == COLOUR_OFF) ? COLOUR_ONE : COLOUR_OFF;
      end else if (led_mode[c] == MODE_OFF_TWO) begin
         led_colour[c] = (s == COLOUR_OFF) ? COLOUR_TWO : COLOUR_OFF;
      end else if (led_mode[c] == MODE_TWO_ONE) begin
         led_colour[c] = (s == COLOUR_TWO) ? COLOUR_ONE : COLOUR_TWO;
      end
   endfunction

   // Returns 1 when the channel can show the requested colour.
   function automatic bit force_colour(input int c, input logic [1:0] value);
      led_blinking[c] = 1'b0;
      if (value == COLOUR_OFF || value == COLOUR_ONE) begin
         led_colour[c] = value;
         return 1'b1;
      end
      if (value == COLOUR_TWO && led_mask[c]) begin
         led_colour[c] = COLOUR_TWO;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic pin_view_type advance_leds(input logic [1:0] kind,
                                                 input logic [2:0] chan,
                                                 input logic [31:0] now_ms,
                                                 input logic [1:0] set_value,
                                                 input logic [15:0] half_ms,
                                                 input logic [1:0] mode);
      pin_view_type view;
      logic [31:0]  elapsed;
      view = '0;
      case (kind)
         KIND_TICK: begin
            n_ticks++;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               elapsed = now_ms - led_last[c];
               if (led_blinking[c] && elapsed >= {16'h0, led_half[c]}) begin
                  led_last[c] = now_ms;
                  step_colour(c);
                  n_toggles++;
               end
            end
         end
         KIND_SET: begin
            view.bad = !force_colour(chan, set_value);
         end
         KIND_BLINK: begin
            led_blinking[chan] = 1'b1;
            led_half[chan]     = half_ms;
            led_mode[chan]     = mode;
         end
         default: begin
            void'(force_colour(chan, COLOUR_OFF));
         end
      endcase
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         view.primary[c]   = (led_colour[c] == COLOUR_ONE);
         view.secondary[c] = (led_colour[c] == COLOUR_TWO) && led_mask[c];
      end
      return view;
   endfunction

   // Results are checked before new items are predicted; an item cannot come out
   // in the cycle it goes in.
   always @(posedge clock) begin
      if (reset) begin
         led_mask = '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            led_blinking[c] = 1'b0;
            led_half[c]     = '0;
            led_mode[c]     = MODE_HOLD;
            led_last[c]     = '0;
            led_colour[c]   = COLOUR_OFF;
         end
         pin_forecast.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            seen_view = '{primary: rsp_tdata[7:0], secondary: rsp_tdata[15:8], bad: rsp_tuser};
            if (pin_forecast.size() == 0) begin
               $error("unexpected result item: pins %h/%h bad %b",
                      seen_view.primary, seen_view.secondary, seen_view.bad);
               fail_count++;
            end else begin
               want_view = pin_forecast.pop_front();
               if (seen_view.bad) n_refused++;
               if (seen_view.primary !== want_view.primary) begin
                  $error("primary_pins: expected %h, actual %h",
                         want_view.primary, seen_view.primary);
                  fail_count++;
               end
               if (seen_view.secondary !== want_view.secondary) begin
                  $error("secondary_pins: expected %h, actual %h",
                         want_view.secondary, seen_view.secondary);
                  fail_count++;
               end
               if (seen_view.bad !== want_view.bad) begin
                  $error("bad_request: expected %b, actual %b", want_view.bad, seen_view.bad);
                  fail_count++;
               end
            end
         end
         if (csr_we) led_mask = csr_wdata;
         if (req_tvalid && req_tready) begin
            n_items++;
            pin_forecast.push_back(advance_leds(req_tuser, req_tdata[2:0], req_tdata[34:3],
                                                req_tdata[36:35], req_tdata[52:37],
                                                req_tdata[54:53]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_led_blink_controller_tb failed");
         $finish;
      end
   end

   // Result side: random stalls per item, plus a long hold-off on request.
   initial begin : rsp_sink
      int unsigned stall;
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
         @(negedge clock);
      end
   end

   // Called and returns at a falling edge.
   task automatic send_item(input logic [1:0] kind, input logic [2:0] chan,
                            input logic [31:0] now_ms, input logic [1:0] set_value,
                            input logic [15:0] half_ms, input logic [1:0] mode);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {1'b0, mode, half_ms, set_value, now_ms, chan};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (pin_forecast.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_mask(input logic [7:0] value);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic test_directed_corners();
      // Single-colour bank: colour two and the invalid code are refused.
      send_item(KIND_SET,   3'd0, '0, COLOUR_ONE,  '0, MODE_HOLD);
      send_item(KIND_SET,   3'd7, '0, COLOUR_TWO,  '0, MODE_HOLD);
      send_item(KIND_SET,   3'd3, '0, SET_INVALID, '0, MODE_HOLD);
      send_item(KIND_SET,   3'd0, '0, COLOUR_OFF,  '0, MODE_HOLD);
      // A single-colour channel alternates off and colour one in any mode.
      send_item(KIND_BLINK, 3'd1, '0, COLOUR_OFF,  16'd0, MODE_OFF_TWO);
      send_item(KIND_TICK,  3'd0, 32'h0, COLOUR_OFF, '0, MODE_HOLD);
      send_item(KIND_TICK,  3'd0, 32'h0, COLOUR_OFF, '0, MODE_HOLD);
      write_mask(8'hFF);
      send_item(KIND_SET,   3'd2, '0, COLOUR_TWO,  '0, MODE_HOLD);
      send_item(KIND_BLINK, 3'd2, '0, COLOUR_OFF,  16'hFFFF, MODE_TWO_ONE);
      send_item(KIND_TICK,  3'd0, 32'h0000_FFFE, COLOUR_OFF, '0, MODE_HOLD);
      send_item(KIND_TICK,  3'd0, 32'h0000_FFFF, COLOUR_OFF, '0, MODE_HOLD);
      send_item(KIND_TICK,  3'd0, 32'hFFFF_FFFF, COLOUR_OFF, '0, MODE_HOLD);
      // Elapsed time wraps through zero here.
      send_item(KIND_TICK,  3'd0, 32'h0000_FFFE, COLOUR_OFF, '0, MODE_HOLD);
      // Mode zero on a two-colour channel records the time but keeps the colour.
      send_item(KIND_BLINK, 3'd4, '0, COLOUR_OFF,  16'd5, MODE_HOLD);
      send_item(KIND_TICK,  3'd0, 32'h0001_0010, COLOUR_OFF, '0, MODE_HOLD);
      send_item(KIND_SET,   3'd5, '0, COLOUR_ONE,  '0, MODE_HOLD);
      send_item(KIND_BLINK, 3'd5, '0, COLOUR_OFF,  16'd1, MODE_OFF_ONE);
      send_item(KIND_BLINK, 3'd6, '0, COLOUR_OFF,  16'd1, MODE_OFF_TWO);
      send_item(KIND_TICK,  3'd0, 32'h0001_0020, COLOUR_OFF, '0, MODE_HOLD);
      send_item(KIND_STOP,  3'd2, '0, COLOUR_OFF,  '0, MODE_HOLD);
      send_item(KIND_SET,   3'd5, '0, SET_INVALID, '0, MODE_HOLD);
      send_item(KIND_SET,   3'd6, '0, COLOUR_TWO,  '0, MODE_HOLD);
      // Channel six keeps colour two after losing its mask bit.
      write_mask(8'h00);
      send_item(KIND_BLINK, 3'd6, '0, COLOUR_OFF,  16'd0, MODE_TWO_ONE);
      send_item(KIND_TICK,  3'd0, 32'h0001_0030, COLOUR_OFF, '0, MODE_HOLD);
      send_item(KIND_STOP,  3'd7, 32'hFFFF_FFFF, SET_INVALID, 16'hFFFF, MODE_TWO_ONE);
      send_item(KIND_TICK,  3'd7, 32'hFFFF_FFFF, SET_INVALID, 16'hFFFF, MODE_TWO_ONE);
   endtask

   // Ticks are the most common item, on a slowly advancing clock and short half
   // periods, so that channels toggle often; unused fields carry random noise.
   task automatic test_random_mix(input logic [7:0] mask, input int count);
      int unsigned pick;
      logic [15:0] half_ms;
      write_mask(mask);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 12);
            send_item(KIND_TICK, 3'($urandom_range(0, 7)), clock_ms,
                      2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                      2'($urandom_range(0, 3)));
         end else if (pick < 70) begin
            case ($urandom_range(0, 15))
               0:       half_ms = 16'($urandom_range(0, 65535));
               1:       half_ms = 16'hFFFF;
               default: half_ms = 16'($urandom_range(0, 24));
            endcase
            send_item(KIND_BLINK, 3'($urandom_range(0, 7)), $urandom,
                      2'($urandom_range(0, 3)), half_ms, 2'($urandom_range(0, 3)));
         end else if (pick < 90) begin
            send_item(KIND_SET, 3'($urandom_range(0, 7)), $urandom,
                      2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                      2'($urandom_range(0, 3)));
         end else begin
            send_item(KIND_STOP, 3'($urandom_range(0, 7)), $urandom,
                      2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                      2'($urandom_range(0, 3)));
         end
      end
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      test_random_mix(8'hAA, 300);
      no_idle = 1'b0;
   endtask

   // The receiver holds off while items keep coming, so the input stalls.
   task automatic test_output_stall();
      wait_results_drained();
      rsp_hold_cycles = 300;
      no_idle = 1'b1;
      test_random_mix(8'($urandom_range(0, 255)), 60);
      no_idle = 1'b0;
      wait_results_drained();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_corners();
      test_random_mix(8'hFF, 400);
      test_back_to_back();
      test_random_mix(8'($urandom_range(0, 255)), 400);
      test_output_stall();
      test_random_mix(8'h55, 400);
      test_random_mix(8'h00, 350);

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pin_forecast.size() != 0) begin
         $error("%0d expected result items never arrived", pin_forecast.size());
         fail_count++;
      end
      $display("Sent %0d items and checked %0d results: %0d ticks, %0d channel toggles,",
               n_items, n_results, n_ticks, n_toggles);
      $display("%0d refused sets; masks all-off, all-on, alternating and random, with a long output stall.",
               n_refused);
      if (fail_count == 0) begin
         $display("multi_led_blink_controller_tb passed");
      end else begin
         $display("multi_led_blink_controller_tb failed");
      end
      $finish;
   end

endmodule
